// File: rtl/core/cdq_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the byte double-ended queue core.
// Used by the core, its RAM-facing sequencer and the port checker; depends on nothing.
package cdq_pkg;

  localparam int KIND_W = 3;
  localparam int CHAR_W = 8;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 7;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DELETE_ALL = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SIZE       = 3'd5;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP,
    ST_DEL
  } state_t;

endpackage

// File: rtl/core/cdq_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
module cdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/char_deque_with_delete_all_core.sv
`timescale 1ns / 1ps
// Top level of the byte double-ended queue: ring buffer in cdq_ram, driven by a small
// sequencer that shares one ring-address adder. Depends on cdq_pkg and cdq_ram.
//
//   channel   ports                                         handshake
//   -------   --------------------------------------------  ---------------------------
//   request   in_kind, in_char_value                        start high while busy low
//   result    out_status, out_popped_value,                 out_valid, one cycle, no stall
//             out_removed_count, out_occupancy
//
// An item is busy in EXEC alone (push, size, pop from an empty queue), in EXEC then POP
// (pop, waiting on the registered RAM read) or in EXEC then DEL (delete all, one entry
// read per cycle through the RAM read port, each compacting write in the cycle after).
// The result strobe follows in the next cycle, when a new item may already be accepted.
// Reset (rst_n low at a clock edge) empties the queue; the RAM contents are not cleared.
// The result side cannot stall.
module char_deque_with_delete_all_core #(
  parameter int DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [cdq_pkg::KIND_W-1:0]  in_kind,
  input  logic [cdq_pkg::CHAR_W-1:0]  in_char_value,
  output logic                        out_valid,
  output logic [cdq_pkg::STAT_W-1:0]  out_status,
  output logic [cdq_pkg::CHAR_W-1:0]  out_popped_value,
  output logic [cdq_pkg::CNT_W-1:0]   out_removed_count,
  output logic [cdq_pkg::CNT_W-1:0]   out_occupancy
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int SW   = CW + 1;
  localparam int OutW = cdq_pkg::CNT_W;
  localparam int ChW  = cdq_pkg::CHAR_W;

  // Ring position of an offset from the front; the sum stays below twice the depth.
  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return AW'(sum);
  endfunction

  cdq_pkg::state_t state_r, state_nxt;

  logic [cdq_pkg::KIND_W-1:0] kind_r, kind_nxt;
  logic [ChW-1:0]             char_r, char_nxt;
  logic [AW-1:0]              front_r, front_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic [CW-1:0]              rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]              kept_r, kept_nxt;
  logic [CW-1:0]              removed_r, removed_nxt;
  logic                       pend_r, pend_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [cdq_pkg::STAT_W-1:0] out_status_r, out_status_nxt;
  logic [ChW-1:0]             out_popped_r, out_popped_nxt;
  logic [OutW-1:0]            out_removed_r, out_removed_nxt;
  logic [OutW-1:0]            out_occ_r, out_occ_nxt;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [ChW-1:0] ram_wdata;
  logic [AW-1:0]  ram_raddr;
  logic [ChW-1:0] ram_rdata;

  logic accept;
  logic is_full;
  logic is_empty;
  logic del_done;
  logic [AW-1:0] ring_addr;
  logic [CW-1:0] ring_off;

  assign accept   = start && (state_r == cdq_pkg::ST_IDLE);
  assign is_full  = (count_r == CW'(DEPTH));
  assign is_empty = (count_r == '0);
  assign del_done = (rd_idx_r == count_r) && !pend_r;

  cdq_ram #(
    .WIDTH(ChW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Offset selection for the shared ring-address adder.
  always_comb begin
    ring_off = rd_idx_r;
    unique case (state_r)
      cdq_pkg::ST_EXEC: begin
        unique case (kind_r)
          cdq_pkg::KIND_PUSH_FRONT: ring_off = CW'(DEPTH - 1);
          cdq_pkg::KIND_PUSH_BACK:  ring_off = count_r;
          cdq_pkg::KIND_POP_BACK:   ring_off = count_r - CW'(1);
          default:                  ring_off = '0;
        endcase
      end
      cdq_pkg::ST_POP: ring_off = CW'(1);
      default:         ring_off = rd_idx_r;
    endcase
  end

  assign ring_addr = ring_pos(front_r, ring_off);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cdq_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = cdq_pkg::ST_EXEC;
        end
      end
      cdq_pkg::ST_EXEC: begin
        unique case (kind_r)
          cdq_pkg::KIND_POP_FRONT, cdq_pkg::KIND_POP_BACK:
            state_nxt = is_empty ? cdq_pkg::ST_IDLE : cdq_pkg::ST_POP;
          cdq_pkg::KIND_DELETE_ALL: state_nxt = cdq_pkg::ST_DEL;
          default:                  state_nxt = cdq_pkg::ST_IDLE;
        endcase
      end
      cdq_pkg::ST_POP: state_nxt = cdq_pkg::ST_IDLE;
      cdq_pkg::ST_DEL: begin
        if (del_done) begin
          state_nxt = cdq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cdq_pkg::ST_IDLE;
    endcase
  end

  // Datapath, RAM control and result.
  always_comb begin
    kind_nxt        = kind_r;
    char_nxt        = char_r;
    front_nxt       = front_r;
    count_nxt       = count_r;
    rd_idx_nxt      = rd_idx_r;
    kept_nxt        = kept_r;
    removed_nxt     = removed_r;
    pend_nxt        = pend_r;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = out_status_r;
    out_popped_nxt  = out_popped_r;
    out_removed_nxt = out_removed_r;
    out_occ_nxt     = out_occ_r;
    ram_we          = 1'b0;
    ram_waddr       = ring_pos(front_r, kept_r);
    ram_wdata       = char_r;
    ram_raddr       = ring_addr;

    unique case (state_r)
      cdq_pkg::ST_IDLE: begin
        if (accept) begin
          kind_nxt = in_kind;
          char_nxt = in_char_value;
        end
      end

      cdq_pkg::ST_EXEC: begin
        out_status_nxt  = cdq_pkg::STAT_DONE;
        out_popped_nxt  = '0;
        out_removed_nxt = '0;
        out_occ_nxt     = OutW'(count_r);
        unique case (kind_r)
          cdq_pkg::KIND_PUSH_FRONT, cdq_pkg::KIND_PUSH_BACK: begin
            out_valid_nxt = 1'b1;
            if (is_full) begin
              out_status_nxt = cdq_pkg::STAT_FULL;
            end else begin
              ram_we      = 1'b1;
              ram_waddr   = ring_addr;
              count_nxt   = count_r + CW'(1);
              out_occ_nxt = OutW'(count_r + CW'(1));
              if (kind_r == cdq_pkg::KIND_PUSH_FRONT) begin
                front_nxt = ring_addr;
              end
            end
          end
          cdq_pkg::KIND_POP_FRONT, cdq_pkg::KIND_POP_BACK: begin
            // A non-empty pop waits in ST_POP for the registered RAM read data.
            if (is_empty) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = cdq_pkg::STAT_EMPTY;
            end
          end
          cdq_pkg::KIND_DELETE_ALL: begin
            rd_idx_nxt  = '0;
            kept_nxt    = '0;
            removed_nxt = '0;
            pend_nxt    = 1'b0;
          end
          default: begin
            out_valid_nxt = 1'b1;
          end
        endcase
      end

      cdq_pkg::ST_POP: begin
        count_nxt       = count_r - CW'(1);
        out_valid_nxt   = 1'b1;
        out_status_nxt  = cdq_pkg::STAT_DONE;
        out_popped_nxt  = ram_rdata;
        out_removed_nxt = '0;
        out_occ_nxt     = OutW'(count_r - CW'(1));
        if (kind_r == cdq_pkg::KIND_POP_FRONT) begin
          front_nxt = ring_addr;
        end
      end

      cdq_pkg::ST_DEL: begin
        // Reads run one entry ahead of the compacting write, which never passes them.
        if (rd_idx_r != count_r) begin
          rd_idx_nxt = rd_idx_r + CW'(1);
          pend_nxt   = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          if (ram_rdata == char_r) begin
            removed_nxt = removed_r + CW'(1);
          end else begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            kept_nxt  = kept_r + CW'(1);
          end
        end
        if (del_done) begin
          count_nxt       = kept_r;
          out_valid_nxt   = 1'b1;
          out_status_nxt  = cdq_pkg::STAT_DONE;
          out_popped_nxt  = '0;
          out_removed_nxt = OutW'(removed_r);
          out_occ_nxt     = OutW'(kept_r);
        end
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cdq_pkg::ST_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r        <= kind_nxt;
    char_r        <= char_nxt;
    rd_idx_r      <= rd_idx_nxt;
    kept_r        <= kept_nxt;
    removed_r     <= removed_nxt;
    out_status_r  <= out_status_nxt;
    out_popped_r  <= out_popped_nxt;
    out_removed_r <= out_removed_nxt;
    out_occ_r     <= out_occ_nxt;
  end

  assign busy              = (state_r != cdq_pkg::ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_popped_value  = out_popped_r;
  assign out_removed_count = out_removed_r;
  assign out_occupancy     = out_occ_r;

endmodule

// File: rtl/core/cdq_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the byte double-ended queue core, bound to its top level.
// Depends on cdq_pkg for result codes and widths.
module cdq_chk #(
  parameter int DEPTH = 64
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_valid,
  input logic [cdq_pkg::STAT_W-1:0] out_status,
  input logic [cdq_pkg::CHAR_W-1:0] out_popped_value,
  input logic [cdq_pkg::CNT_W-1:0]  out_removed_count,
  input logic [cdq_pkg::CNT_W-1:0]  out_occupancy
);

  localparam int OutW = cdq_pkg::CNT_W;

  // An accepted item always raises busy in the cycle after it is taken.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // Each item yields one result, and the block is free again when it shows.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // A rejected push only happens with the queue at capacity.
  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == cdq_pkg::STAT_FULL) |-> out_occupancy == OutW'(DEPTH))
    else $error("full status with queue not at capacity");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != cdq_pkg::STAT_DONE)
      |-> (out_popped_value == '0) && (out_removed_count == '0))
    else $error("failed request carries nonzero data");

endmodule

bind char_deque_with_delete_all_core cdq_chk #(.DEPTH(DEPTH)) u_cdq_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_status       (out_status),
  .out_popped_value (out_popped_value),
  .out_removed_count(out_removed_count),
  .out_occupancy    (out_occupancy)
);
